FILE: sv/cpcc_pkg.sv
// Shared types, constants and channel tables for the color probe cascade classifier.
// Used by cpcc_cell and color_probe_cascade_classifier; depends on nothing else.
`default_nettype none

package cpcc_pkg;

  localparam int unsigned PairCodes  = 18;
  localparam int unsigned GateAGreen = 50;
  localparam int unsigned GateLevel  = 60;

  typedef logic [3:0][23:0] probe_set_t;

  typedef struct packed {
    logic               valid;
    logic               load;
    logic               pass;
    probe_set_t         probes;
    logic [3:0]         stage_index;
    logic [4:0]         pair_code;
    logic signed [15:0] multiplier;
    logic signed [31:0] upper_bound;
    logic signed [31:0] lower_bound;
  } word_t;

  function automatic logic [3:0] first_ch(input logic [4:0] code);
    logic [3:0] c;
    unique case (code)
      5'd0, 5'd1, 5'd2:   c = 4'd0;
      5'd3, 5'd4, 5'd5:   c = 4'd1;
      5'd6, 5'd7, 5'd8:   c = 4'd2;
      5'd9, 5'd10:        c = 4'd3;
      5'd11, 5'd12:       c = 4'd4;
      5'd13, 5'd14:       c = 4'd5;
      5'd15:              c = 4'd6;
      5'd16:              c = 4'd7;
      5'd17:              c = 4'd8;
      default:            c = 4'd0;
    endcase
    return c;
  endfunction

  function automatic logic [3:0] second_ch(input logic [4:0] code);
    logic [3:0] c;
    unique case (code)
      5'd0:               c = 4'd3;
      5'd1, 5'd9:         c = 4'd6;
      5'd2, 5'd10, 5'd15: c = 4'd9;
      5'd3:               c = 4'd4;
      5'd4, 5'd11:        c = 4'd7;
      5'd5, 5'd12, 5'd16: c = 4'd10;
      5'd6:               c = 4'd5;
      5'd7, 5'd13:        c = 4'd8;
      5'd8, 5'd14, 5'd17: c = 4'd11;
      default:            c = 4'd0;
    endcase
    return c;
  endfunction

  // Channel c sits in probe c/3; red, green and blue follow in that order.
  function automatic logic [7:0] channel(input probe_set_t p, input logic [3:0] c);
    logic [7:0] v;
    unique case (c)
      4'd0:    v = p[0][23:16];
      4'd1:    v = p[0][15:8];
      4'd2:    v = p[0][7:0];
      4'd3:    v = p[1][23:16];
      4'd4:    v = p[1][15:8];
      4'd5:    v = p[1][7:0];
      4'd6:    v = p[2][23:16];
      4'd7:    v = p[2][15:8];
      4'd8:    v = p[2][7:0];
      4'd9:    v = p[3][23:16];
      4'd10:   v = p[3][15:8];
      4'd11:   v = p[3][7:0];
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: sv/cpcc_cell.sv
// One cascade stage: holds its stage entry and passes words on in two register steps.
// Depends on cpcc_pkg for the word type and the channel tables.
`default_nettype none

module cpcc_cell #(
  parameter int unsigned IDX = 0
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           adv,
  input  wire logic [3:0]     shift,
  input  wire cpcc_pkg::word_t word_in,
  output cpcc_pkg::word_t     word_out
);

  logic [4:0]         pair_r;
  logic signed [15:0] mult_r;
  logic signed [31:0] upper_r;
  logic signed [31:0] lower_r;

  cpcc_pkg::word_t    mid_word_r;
  cpcc_pkg::word_t    mid_word_nxt;
  logic signed [24:0] prod_r;
  logic signed [24:0] prod_nxt;
  logic [22:0]        shl_r;
  logic [22:0]        shl_nxt;
  cpcc_pkg::word_t    out_word_r;
  cpcc_pkg::word_t    out_word_nxt;

  logic               hit;
  logic [7:0]         ch1;
  logic [7:0]         ch2;
  logic               code_ok;
  logic signed [33:0] diff;
  logic               in_range;

  assign hit = word_in.valid && word_in.load && (32'(word_in.stage_index) == IDX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_r  <= '0;
      mult_r  <= '0;
      upper_r <= '0;
      lower_r <= '0;
    end else if (adv && hit) begin
      pair_r  <= word_in.pair_code;
      mult_r  <= word_in.multiplier;
      upper_r <= word_in.upper_bound;
      lower_r <= word_in.lower_bound;
    end
  end

  always_comb begin
    ch1      = cpcc_pkg::channel(word_in.probes, cpcc_pkg::first_ch(pair_r));
    ch2      = cpcc_pkg::channel(word_in.probes, cpcc_pkg::second_ch(pair_r));
    code_ok  = (32'(pair_r) < cpcc_pkg::PairCodes);
    prod_nxt = $signed({17'b0, ch1}) * $signed({{9{mult_r[15]}}, mult_r});
    shl_nxt  = {15'b0, ch2} << shift;
    mid_word_nxt      = word_in;
    mid_word_nxt.pass = word_in.pass && code_ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_word_r <= '0;
    end else if (adv) begin
      mid_word_r <= mid_word_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= prod_nxt;
      shl_r  <= shl_nxt;
    end
  end

  always_comb begin
    diff     = $signed({11'b0, shl_r}) - $signed({{9{prod_r[24]}}, prod_r});
    in_range = (diff < $signed({{2{upper_r[31]}}, upper_r})) &&
               (diff > $signed({{2{lower_r[31]}}, lower_r}));
    out_word_nxt      = mid_word_r;
    out_word_nxt.pass = mid_word_r.pass && in_range;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_word_r <= '0;
    end else if (adv) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign word_out = out_word_r;

endmodule

`default_nettype wire

FILE: sv/color_probe_cascade_classifier.sv
// Top level of the color probe cascade classifier: brightness gate, cell chain, result register.
// Depends on cpcc_pkg and cpcc_cell.
`default_nettype none

// Every accepted word enters a chain of STAGE_COUNT cells and moves one register step per
// cycle while the output does not stall, so one word is taken each such cycle, and a classify
// result passes through every cell and then the result register. Load words travel the
// same chain and update their cell as they pass it, so they stay in order with classify
// words. The whole chain holds while a result waits on a stalled output.

module color_probe_cascade_classifier #(
  parameter int unsigned STAGE_COUNT = 15
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [3:0]         cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_cmd,
  input  wire logic [23:0]        in_probe_a,
  input  wire logic [23:0]        in_probe_b,
  input  wire logic [23:0]        in_probe_c,
  input  wire logic [23:0]        in_probe_d,
  input  wire logic [3:0]         in_stage_index,
  input  wire logic [4:0]         in_pair_code,
  input  wire logic signed [15:0] in_multiplier,
  input  wire logic signed [31:0] in_upper_bound,
  input  wire logic signed [31:0] in_lower_bound,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_probe_fit
);

  logic            [3:0] class_shift_r;
  logic                  out_valid_r;
  logic                  out_fit_r;
  logic                  adv;
  logic                  gate_ok;
  cpcc_pkg::word_t       entry_word;
  cpcc_pkg::word_t       chain [STAGE_COUNT+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      class_shift_r <= '0;
    end else if (cfg_we) begin
      class_shift_r <= cfg_wdata;
    end
  end

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  always_comb begin
    gate_ok = (32'(in_probe_a[15:8])  >= cpcc_pkg::GateAGreen) &&
              (32'(in_probe_b[7:0])   >= cpcc_pkg::GateLevel) &&
              (32'(in_probe_b[15:8])  >= cpcc_pkg::GateLevel) &&
              (32'(in_probe_b[23:16]) >= cpcc_pkg::GateLevel) &&
              (32'(in_probe_c[23:16]) >= cpcc_pkg::GateLevel);
    entry_word             = '0;
    entry_word.valid       = in_valid;
    entry_word.load        = in_cmd;
    entry_word.pass        = gate_ok;
    entry_word.probes[0]   = in_probe_a;
    entry_word.probes[1]   = in_probe_b;
    entry_word.probes[2]   = in_probe_c;
    entry_word.probes[3]   = in_probe_d;
    entry_word.stage_index = in_stage_index;
    entry_word.pair_code   = in_pair_code;
    entry_word.multiplier  = in_multiplier;
    entry_word.upper_bound = in_upper_bound;
    entry_word.lower_bound = in_lower_bound;
  end

  assign chain[0] = entry_word;

  for (genvar i = 0; i < STAGE_COUNT; i++) begin : g_cell
    cpcc_cell #(
      .IDX(i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .shift   (class_shift_r),
      .word_in (chain[i]),
      .word_out(chain[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= chain[STAGE_COUNT].valid && !chain[STAGE_COUNT].load;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_fit_r <= chain[STAGE_COUNT].pass;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_probe_fit = out_fit_r;

  a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while the result register could advance");

  a_classify_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && chain[STAGE_COUNT].valid && !chain[STAGE_COUNT].load) |=> out_valid)
    else $error("classify word left the chain without a result");

  a_load_gives_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && chain[STAGE_COUNT].valid && chain[STAGE_COUNT].load) |=> !out_valid)
    else $error("load word produced a result");

  a_shift_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(cfg_we) |-> $stable(class_shift_r))
    else $error("shift register changed without a write");

endmodule

`default_nettype wire
